// ===== hdl/tsoc_pkg.sv =====
package tsoc_pkg;

    // width of the count field on the result port
    localparam int unsigned COUNT_OUT_W = 13;

    // sequencer states, one-hot
    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_SQ   = 10'b00_0000_0010,
        S_M1   = 10'b00_0000_0100,
        S_M2   = 10'b00_0000_1000,
        S_M3   = 10'b00_0001_0000,
        S_M4   = 10'b00_0010_0000,
        S_M5   = 10'b00_0100_0000,
        S_M6   = 10'b00_1000_0000,
        S_M7   = 10'b01_0000_0000,
        S_M8   = 10'b10_0000_0000
    } t_state;

    // control from the sequencer to the datapath
    typedef struct packed {
        t_state st;
        logic   ready;
        logic   mul_en;
        logic   emit;
    } t_ctrl;

endpackage

// ===== hdl/tsoc_mul.sv =====
module tsoc_mul
    import tsoc_pkg::*;
#(
    parameter int unsigned OP_W = 31
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [OP_W-1:0]     i_a,
    input  logic signed [OP_W-1:0]     i_b,
    output logic signed [2*OP_W-1:0]   o_prod
);

    logic signed [2*OP_W-1:0] r_prod;
    logic signed [2*OP_W-1:0] n_prod;

    // shared signed multiplier with registered product
    assign n_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/tsoc_ctrl.sv =====
module tsoc_ctrl
    import tsoc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  logic  i_last,
    input  logic  i_out_free,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    // step through the final test once the last item is squared
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_accept) n_state = S_SQ;
            S_SQ:    n_state = i_last ? S_M1 : S_IDLE;
            S_M1:    n_state = S_M2;
            S_M2:    n_state = S_M3;
            S_M3:    n_state = S_M4;
            S_M4:    n_state = S_M5;
            S_M5:    n_state = S_M6;
            S_M6:    n_state = S_M7;
            S_M7:    n_state = S_M8;
            S_M8:    if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control word
    always_comb begin
        o_ctrl.st     = r_state;
        o_ctrl.ready  = (r_state == S_IDLE);
        o_ctrl.mul_en = (r_state != S_IDLE) && (r_state != S_M8);
        o_ctrl.emit   = (r_state == S_M8) && i_out_free;
    end

endmodule

// ===== hdl/three_sigma_outlier_check.sv =====
// Three-sigma outlier check over a streamed set of signed samples.
// Input channel: i_valid / o_ready carry i_sample and i_last_sample, one
// sample per item; i_last_sample marks the final sample of a set.
// Output channel: o_valid / i_ready carry one result per set: o_rule_holds,
// o_sample_count (saturated at MAX_SAMPLES) and o_count_overflow.
// Each sample is accepted in S_IDLE, which updates count, sum, minimum and
// maximum, and then squared on the shared multiplier in S_SQ. After the
// last sample the same multiplier works out sum^2, n*sumsq (two halves),
// n*min, n*max and the two squared deviations in S_M1 to S_M7; the result
// is registered when S_M8 finds the output free, and o_ready returns in
// the same cycle. The exact test is (n*x - sum)^2 >= 9*(n*sumsq - sum^2)
// for the minimum and the maximum; a set of equal samples fails it.
// Samples past MAX_SAMPLES are dropped and only raise the overflow flag.
// Reset clears the set statistics and drops any pending result. If the
// receiver stalls, the result waits in the output register and the block
// may take and accumulate the next set; only its final test waits.
module three_sigma_outlier_check
    import tsoc_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = 4096,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [15:0]      i_sample,
    input  logic                    i_last_sample,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_rule_holds,
    output logic [COUNT_OUT_W-1:0]  o_sample_count,
    output logic                    o_count_overflow
);

    localparam int unsigned SB     = SAMPLE_BITS;
    localparam int unsigned CW     = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned SUM_W  = SB + CW;
    localparam int unsigned SQ_W   = 2 * SB + CW - 2;
    localparam int unsigned OP_W   = SUM_W + 2;
    localparam int unsigned PROD_W = 2 * OP_W;
    localparam int unsigned LO_W   = OP_W - 1;
    localparam int unsigned ACC_W  = PROD_W + 4;

    t_ctrl ctrl;
    logic  accept;
    logic  out_free;

    logic [CW-1:0]              r_count;
    logic signed [SUM_W-1:0]    r_sum;
    logic [SQ_W-1:0]            r_sumsq;
    logic signed [SB-1:0]       r_min;
    logic signed [SB-1:0]       r_max;
    logic                       r_ovf;
    logic signed [SB-1:0]       r_x;
    logic                       r_last;
    logic                       r_use;
    logic                       r_pend;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [OP_W-1:0]     r_d;
    logic                       r_fail;
    logic                       r_ovalid;
    logic                       r_holds;
    logic [COUNT_OUT_W-1:0]     r_ocount;
    logic                       r_oovf;

    logic signed [SB-1:0]       x_in;
    logic signed [OP_W-1:0]     op_a;
    logic signed [OP_W-1:0]     op_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [OP_W-1:0]     n_op;
    logic                       cmp;

    assign accept   = i_valid && ctrl.ready;
    assign out_free = !r_ovalid || i_ready;
    assign x_in     = i_sample[SB-1:0];
    assign n_op     = OP_W'(r_count);
    assign cmp      = (ACC_W'(prod) >= r_acc);

    tsoc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_last     (r_last),
        .i_out_free (out_free),
        .o_ctrl     (ctrl)
    );

    // operand selection for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (ctrl.st)
            S_SQ: begin
                op_a = OP_W'(r_x);
                op_b = OP_W'(r_x);
            end
            S_M1: begin
                op_a = OP_W'(r_sum);
                op_b = OP_W'(r_sum);
            end
            S_M2: begin
                op_a = n_op;
                op_b = $signed({1'b0, r_sumsq[LO_W-1:0]});
            end
            S_M3: begin
                op_a = n_op;
                op_b = $signed(OP_W'(r_sumsq[SQ_W-1:LO_W]));
            end
            S_M4: begin
                op_a = n_op;
                op_b = OP_W'(r_min);
            end
            S_M5: begin
                op_a = n_op;
                op_b = OP_W'(r_max);
            end
            S_M6, S_M7: begin
                op_a = r_d;
                op_b = r_d;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    tsoc_mul #(
        .OP_W (OP_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en   (ctrl.mul_en),
        .i_a    (op_a),
        .i_b    (op_b),
        .o_prod (prod)
    );

    // set statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || ctrl.emit) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_min   <= {1'b0, {(SB-1){1'b1}}};
            r_max   <= {1'b1, {(SB-1){1'b0}}};
            r_ovf   <= 1'b0;
            r_pend  <= 1'b0;
            r_use   <= 1'b0;
        end else begin
            if (accept) begin
                if (r_count >= CW'(MAX_SAMPLES)) begin
                    r_ovf <= 1'b1;
                    r_use <= 1'b0;
                end else begin
                    r_count <= r_count + CW'(1);
                    r_sum   <= r_sum + SUM_W'(x_in);
                    r_use   <= 1'b1;
                    if (x_in < r_min) r_min <= x_in;
                    if (x_in > r_max) r_max <= x_in;
                end
            end
            // square lands in the cycle after the multiply
            if (ctrl.st == S_SQ) begin
                r_pend <= r_use;
            end else begin
                r_pend <= 1'b0;
            end
            if (r_pend) begin
                r_sumsq <= r_sumsq + prod[SQ_W-1:0];
            end
        end
    end

    // sample and mark held for the square step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= 1'b0;
        end else if (accept) begin
            r_last <= i_last_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= x_in;
        end
    end

    // spread accumulator, deviation and outcome of the minimum's test
    always_ff @(posedge i_clk) begin
        case (ctrl.st)
            S_M2: r_acc <= -ACC_W'(prod);
            S_M3: r_acc <= r_acc + ACC_W'(prod);
            S_M4: r_acc <= r_acc + (ACC_W'(prod) <<< LO_W);
            S_M5: begin
                r_acc <= (r_acc <<< 3) + r_acc;
                r_d   <= OP_W'(prod - PROD_W'(r_sum));
            end
            S_M6: r_d <= OP_W'(prod - PROD_W'(r_sum));
            S_M7: r_fail <= cmp;
            default: r_acc <= r_acc;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (ctrl.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit) begin
            r_holds  <= !(r_fail || cmp);
            r_ocount <= COUNT_OUT_W'(r_count);
            r_oovf   <= r_ovf;
        end
    end

    assign o_ready          = ctrl.ready;
    assign o_valid          = r_ovalid;
    assign o_rule_holds     = r_holds;
    assign o_sample_count   = r_ocount;
    assign o_count_overflow = r_oovf;

endmodule

// ===== sim/tb_three_sigma_outlier_check.sv =====
module tb_three_sigma_outlier_check;
    timeunit 1ns;
    timeprecision 1ps;

    import tsoc_pkg::*;

    localparam int MAX_SAMPLES = 4096;
    localparam int CYCLE_LIMIT = 400000;

    // shape of the samples in one random set
    typedef enum int {
        SHAPE_WIDE,
        SHAPE_NARROW,
        SHAPE_FLAT,
        SHAPE_SPIKE
    } t_set_shape;

    // verdict the block should give for one set
    typedef struct {
        logic                   holds;
        logic [COUNT_OUT_W-1:0] count;
        logic                   overflow;
    } t_set_verdict;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic signed [15:0]     i_sample = '0;
    logic                   i_last_sample = 1'b0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic                   o_rule_holds;
    logic [COUNT_OUT_W-1:0] o_sample_count;
    logic                   o_count_overflow;

    // running statistics of the set being streamed in
    longint set_count;
    longint set_sum;
    longint set_square_sum;
    longint set_min;
    longint set_max;
    bit     set_overflow;

    t_set_verdict verdict_q[$];
    int           verdict_errors = 0;
    int           cycle_count = 0;
    int           send_gap_max = 0;
    int           recv_gap_max = 0;
    int           recv_hold_req = 0;

    three_sigma_outlier_check u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample         (i_sample),
        .i_last_sample    (i_last_sample),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_rule_holds     (o_rule_holds),
        .o_sample_count   (o_sample_count),
        .o_count_overflow (o_count_overflow)
    );

    always #5ns i_clk = ~i_clk;

    // run time guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // fresh statistics for the next set
    function automatic void clear_set_stats();
        set_count      = 0;
        set_sum        = 0;
        set_square_sum = 0;
        set_min        = 32767;
        set_max        = -32768;
        set_overflow   = 1'b0;
    endfunction

    // fold one accepted sample in; on the last one work out the verdict
    function automatic void accumulate_sample(logic signed [15:0] s, logic last);
        longint       x;
        longint       spread9;
        longint       dev_lo;
        longint       dev_hi;
        t_set_verdict v;
        x = s;
        if (set_count >= MAX_SAMPLES) begin
            set_overflow = 1'b1;
        end else begin
            set_count++;
            set_sum        += x;
            set_square_sum += x * x;
            if (x < set_min) set_min = x;
            if (x > set_max) set_max = x;
        end
        if (last) begin
            spread9    = 9 * (set_count * set_square_sum - set_sum * set_sum);
            dev_lo     = set_count * set_min - set_sum;
            dev_hi     = set_count * set_max - set_sum;
            v.holds    = !(dev_lo * dev_lo >= spread9) && !(dev_hi * dev_hi >= spread9);
            v.count    = set_count[COUNT_OUT_W-1:0];
            v.overflow = set_overflow;
            verdict_q.push_back(v);
            clear_set_stats();
        end
    endfunction

    // compare one accepted result with the oldest expected verdict
    function automatic void check_verdict();
        t_set_verdict want;
        if (verdict_q.size() == 0) begin
            verdict_errors++;
            if (verdict_errors <= 10)
                $display("unexpected result: holds %b count %0d overflow %b",
                         o_rule_holds, o_sample_count, o_count_overflow);
        end else begin
            want = verdict_q.pop_front();
            if (o_rule_holds !== want.holds || o_sample_count !== want.count ||
                o_count_overflow !== want.overflow) begin
                verdict_errors++;
                if (verdict_errors <= 10)
                    $display("result mismatch: holds %b/%b count %0d/%0d overflow %b/%b",
                             want.holds, o_rule_holds, want.count, o_sample_count,
                             want.overflow, o_count_overflow);
            end
        end
    endfunction

    // hand one sample to the block after a random gap
    task automatic send_sample(input logic signed [15:0] s, input logic last);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_sample      <= s;
        i_last_sample <= last;
        do @(posedge i_clk); while (!o_ready);
        accumulate_sample(s, last);
    endtask

    // result side: random stalls per item, long hold on request
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                check_verdict();
                stall_left = $urandom_range(0, recv_gap_max);
            end
            if (recv_hold_req > 0) begin
                hold_left     = recv_hold_req;
                recv_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // extremes, zero variance and the exact three-sigma boundary
    task automatic test_directed_sets();
        int k;
        send_gap_max = 8;
        recv_gap_max = 8;
        // set of one sample
        send_sample(16'sh7fff, 1'b1);
        // equal samples at the most negative value
        repeat (2) send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b1);
        // both extremes in one set
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b1);
        // one far sample among nine equal ones lands exactly on three sigmas
        for (k = 0; k < 9; k++) send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b1);
        // alternating bit patterns and values around zero
        send_sample(16'sh5555, 1'b0);
        send_sample(16'shaaaa, 1'b0);
        send_sample(16'shffff, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh0001, 1'b1);
    endtask

    // receiver holds off while sets keep coming, so the input stalls
    task automatic test_pressure_stall();
        int k;
        int j;
        send_gap_max  = 0;
        recv_gap_max  = 0;
        recv_hold_req = 400;
        for (k = 0; k < 4; k++) begin
            for (j = 0; j < 6; j++) send_sample(16'($urandom), j == 5);
        end
    endtask

    // a set that fills to the sample limit and then runs past it
    task automatic test_count_saturation();
        int k;
        send_gap_max = 0;
        recv_gap_max = 4;
        for (k = 0; k < MAX_SAMPLES; k++)
            send_sample(16'(int'($urandom_range(0, 200)) - 100), 1'b0);
        // the samples past the limit would be outliers if they were counted
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b1);
    endtask

    // random sets of mixed shapes and lengths
    task automatic test_random_sets();
        int         sent;
        int         set_len;
        int         centre;
        int         width;
        int         spike_at;
        int         v;
        int         k;
        t_set_shape shape;
        sent = 0;
        while (sent < 400) begin
            // switch idling on and off in stretches
            if ($urandom_range(0, 3) == 0) begin
                send_gap_max = $urandom_range(0, 1) * 8;
                recv_gap_max = $urandom_range(0, 1) * 8;
            end
            shape    = t_set_shape'($urandom_range(0, 3));
            set_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 14);
            if (shape == SHAPE_SPIKE) set_len = $urandom_range(8, 24);
            centre   = int'($urandom_range(0, 65535)) - 32768;
            width    = 1 << $urandom_range(0, 14);
            spike_at = $urandom_range(0, set_len - 1);
            for (k = 0; k < set_len; k++) begin
                case (shape)
                    SHAPE_WIDE: begin
                        v = int'($urandom_range(0, 65535)) - 32768;
                    end
                    SHAPE_FLAT: begin
                        v = centre;
                    end
                    default: begin
                        v = centre + int'($urandom_range(0, width)) - width / 2;
                        if (v > 32767) v = 32767;
                        if (v < -32768) v = -32768;
                    end
                endcase
                if (shape == SHAPE_SPIKE && k == spike_at)
                    v = (centre < 0) ? 32767 : -32768;
                send_sample(16'(v), k == set_len - 1);
            end
            sent += set_len;
        end
    endtask

    initial begin
        clear_set_stats();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_sets();
        test_pressure_stall();
        test_count_saturation();
        test_random_sets();
        i_valid <= 1'b0;
        recv_gap_max = 0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (verdict_errors == 0 && verdict_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
